>>> sv/gcc_pkg.sv
// ----------------------------------------------------------------------------
// Greedy coin change package
// Shared constants, mode codes and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package gcc_pkg;

    localparam int MAX_DENOMS_DEF = 16;
    localparam int VALUE_W        = 16;
    localparam int POS_W          = 4;
    localparam int AMOUNT_W       = 32;
    localparam int ENTRY_W        = POS_W + VALUE_W;
    localparam int DIV_STEPS      = AMOUNT_W;
    localparam int STEP_W         = $clog2(DIV_STEPS);

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_SOLVE = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic latch;
        logic ptr_from_cnt;
        logic ptr_clr;
        logic ptr_inc;
        logic rd_prev;
        logic shift_wr;
        logic ins_wr;
        logic cnt_clr;
        logic take_entry;
        logic zero_res;
        logic div_start;
        logic div_res;
        logic empty_res;
    } gcc_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic ptr_zero;
        logic rd_less;
        logic val_zero;
        logic div_done;
        logic last;
    } gcc_sts_t;

endpackage

>>> sv/gcc_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/gcc_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring 32-by-16 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gcc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [gcc_pkg::AMOUNT_W-1:0] dividend,
    input  logic [gcc_pkg::VALUE_W-1:0]  divisor,
    output logic                         done,
    output logic [gcc_pkg::AMOUNT_W-1:0] quot,
    output logic [gcc_pkg::AMOUNT_W-1:0] rem
);

    logic [gcc_pkg::AMOUNT_W-1:0] q_reg, q_next;
    logic [gcc_pkg::AMOUNT_W-1:0] r_reg, r_next;
    logic [gcc_pkg::VALUE_W-1:0]  d_reg;
    logic [gcc_pkg::STEP_W-1:0]   step_reg, step_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [gcc_pkg::AMOUNT_W:0]   trial;
    logic [gcc_pkg::AMOUNT_W:0]   diff;
    logic                         ge;

    always_comb
    begin
        trial     = {r_reg, q_reg[gcc_pkg::AMOUNT_W-1]};
        ge        = trial >= (gcc_pkg::AMOUNT_W+1)'(d_reg);
        diff      = trial - (gcc_pkg::AMOUNT_W+1)'(d_reg);
        q_next    = q_reg;
        r_next    = r_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            step_next = gcc_pkg::STEP_W'(gcc_pkg::DIV_STEPS - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // The partial remainder stays below the divisor, so it fits 32 bits.
            r_next    = ge ? diff[gcc_pkg::AMOUNT_W-1:0] : trial[gcc_pkg::AMOUNT_W-1:0];
            q_next    = {q_reg[gcc_pkg::AMOUNT_W-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        if (start)
        begin
            d_reg <= divisor;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

>>> sv/gcc_dp.sv
// ----------------------------------------------------------------------------
// Greedy coin change datapath
// Denomination table, entry count, walk pointer, divider and result registers.
// ----------------------------------------------------------------------------
module gcc_dp #(
    parameter int MAX_DENOMS = gcc_pkg::MAX_DENOMS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  gcc_pkg::gcc_cmd_t            cmd,
    output gcc_pkg::gcc_sts_t            sts,
    input  logic [gcc_pkg::VALUE_W-1:0]  coin_value,
    input  logic [gcc_pkg::AMOUNT_W-1:0] amount,
    output logic [gcc_pkg::POS_W-1:0]    denom_index,
    output logic [gcc_pkg::VALUE_W-1:0]  denom_value,
    output logic [gcc_pkg::AMOUNT_W-1:0] unit_count,
    output logic [gcc_pkg::AMOUNT_W-1:0] remainder,
    output logic                         feasible,
    output logic                         is_last
);

    localparam int CW = $clog2(MAX_DENOMS + 1);
    localparam int AW = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
    localparam int PW = (CW > gcc_pkg::POS_W) ? CW : gcc_pkg::POS_W;

    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [CW-1:0]                ptr_reg, ptr_next;
    logic [gcc_pkg::VALUE_W-1:0]  coin_reg;
    logic [gcc_pkg::AMOUNT_W-1:0] rem_reg;
    logic [gcc_pkg::VALUE_W-1:0]  ent_val_reg;
    logic [gcc_pkg::POS_W-1:0]    ent_pos_reg;
    logic [gcc_pkg::POS_W-1:0]    o_idx_reg;
    logic [gcc_pkg::VALUE_W-1:0]  o_val_reg;
    logic [gcc_pkg::AMOUNT_W-1:0] o_cnt_reg;
    logic [gcc_pkg::AMOUNT_W-1:0] o_rem_reg;
    logic                         o_feas_reg;
    logic                         o_last_reg;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [gcc_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [gcc_pkg::ENTRY_W-1:0]  ram_rdata;
    logic [gcc_pkg::VALUE_W-1:0]  rd_val;
    logic [gcc_pkg::POS_W-1:0]    rd_pos;
    logic [CW-1:0]                ptr_m1;
    logic [CW-1:0]                ptr_p1;
    logic [PW-1:0]                cnt_ext;
    logic                         last_now;
    logic                         div_done;
    logic [gcc_pkg::AMOUNT_W-1:0] div_q;
    logic [gcc_pkg::AMOUNT_W-1:0] div_r;

    assign rd_val   = ram_rdata[gcc_pkg::VALUE_W-1:0];
    assign rd_pos   = ram_rdata[gcc_pkg::ENTRY_W-1:gcc_pkg::VALUE_W];
    assign ptr_m1   = ptr_reg - 1'b1;
    assign ptr_p1   = ptr_reg + 1'b1;
    assign cnt_ext  = PW'(cnt_reg);
    assign last_now = (ptr_p1 == cnt_reg);

    assign ram_we    = cmd.shift_wr | cmd.ins_wr;
    assign ram_waddr = AW'(ptr_reg);
    assign ram_wdata = cmd.shift_wr ? ram_rdata
                                    : {cnt_ext[gcc_pkg::POS_W-1:0], coin_reg};
    assign ram_raddr = cmd.rd_prev ? AW'(ptr_m1) : AW'(ptr_reg);

    gcc_ram #(
        .WIDTH (gcc_pkg::ENTRY_W),
        .DEPTH (MAX_DENOMS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gcc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rem_reg),
        .divisor  (rd_val),
        .done     (div_done),
        .quot     (div_q),
        .rem      (div_r)
    );

    always_comb
    begin
        cnt_next = cnt_reg;
        ptr_next = ptr_reg;
        if (cmd.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (cmd.ins_wr)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.ptr_from_cnt)
        begin
            ptr_next = cnt_reg;
        end
        else if (cmd.ptr_clr)
        begin
            ptr_next = '0;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_p1;
        end
        else if (cmd.shift_wr)
        begin
            ptr_next = ptr_m1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ptr_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ptr_reg <= ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            coin_reg <= coin_value;
            rem_reg  <= amount;
        end
        if (cmd.take_entry)
        begin
            ent_val_reg <= rd_val;
            ent_pos_reg <= rd_pos;
        end
        if (cmd.zero_res)
        begin
            // A zero denomination takes no units and passes the amount on.
            o_idx_reg  <= rd_pos;
            o_val_reg  <= rd_val;
            o_cnt_reg  <= '0;
            o_rem_reg  <= rem_reg;
            o_last_reg <= last_now;
            o_feas_reg <= last_now && (rem_reg == '0);
        end
        if (cmd.div_res)
        begin
            o_idx_reg  <= ent_pos_reg;
            o_val_reg  <= ent_val_reg;
            o_cnt_reg  <= div_q;
            o_rem_reg  <= div_r;
            rem_reg    <= div_r;
            o_last_reg <= last_now;
            o_feas_reg <= last_now && (div_r == '0);
        end
        if (cmd.empty_res)
        begin
            o_idx_reg  <= '0;
            o_val_reg  <= '0;
            o_cnt_reg  <= '0;
            o_rem_reg  <= rem_reg;
            o_last_reg <= 1'b1;
            o_feas_reg <= (rem_reg == '0);
        end
    end

    assign sts.full     = (cnt_reg == CW'(MAX_DENOMS));
    assign sts.empty    = (cnt_reg == '0);
    assign sts.ptr_zero = (ptr_reg == '0);
    assign sts.rd_less  = (rd_val < coin_reg);
    assign sts.val_zero = (rd_val == '0);
    assign sts.div_done = div_done;
    assign sts.last     = o_last_reg;

    assign denom_index = o_idx_reg;
    assign denom_value = o_val_reg;
    assign unit_count  = o_cnt_reg;
    assign remainder   = o_rem_reg;
    assign feasible    = o_feas_reg;
    assign is_last     = o_last_reg;

endmodule

>>> sv/gcc_ctrl.sv
// ----------------------------------------------------------------------------
// Greedy coin change controller
// Sequences table insertion and the per-denomination solve walk.
// ----------------------------------------------------------------------------
module gcc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    output logic              out_valid,
    input  logic              out_ready,
    output gcc_pkg::gcc_cmd_t cmd,
    input  gcc_pkg::gcc_sts_t sts
);

    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_INS_CHK   = 8'b0000_0010,
        ST_INS_CMP   = 8'b0000_0100,
        ST_SOL_RD    = 8'b0000_1000,
        ST_SOL_START = 8'b0001_0000,
        ST_SOL_WAIT  = 8'b0010_0000,
        ST_EMPTY     = 8'b0100_0000,
        ST_OUT       = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.latch = 1'b1;
                    priority if (mode == gcc_pkg::MODE_LOAD)
                    begin
                        // A load into a full table is dropped.
                        if (!sts.full)
                        begin
                            cmd.ptr_from_cnt = 1'b1;
                            state_next       = ST_INS_CHK;
                        end
                    end
                    else if (mode == gcc_pkg::MODE_SOLVE)
                    begin
                        cmd.ptr_clr = 1'b1;
                        state_next  = sts.empty ? ST_EMPTY : ST_SOL_RD;
                    end
                    else if (mode == gcc_pkg::MODE_CLEAR)
                    begin
                        cmd.cnt_clr = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_INS_CHK:
            begin
                if (sts.ptr_zero)
                begin
                    cmd.ins_wr = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.rd_prev = 1'b1;
                    state_next  = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                // Smaller entries move up one slot; equal values keep load order.
                if (sts.rd_less)
                begin
                    cmd.shift_wr = 1'b1;
                    state_next   = ST_INS_CHK;
                end
                else
                begin
                    cmd.ins_wr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SOL_RD:
            begin
                state_next = ST_SOL_START;
            end
            ST_SOL_START:
            begin
                cmd.take_entry = 1'b1;
                if (sts.val_zero)
                begin
                    cmd.zero_res = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_SOL_WAIT;
                end
            end
            ST_SOL_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.div_res = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_EMPTY:
            begin
                cmd.empty_res = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    if (sts.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.ptr_inc = 1'b1;
                        state_next  = ST_SOL_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> sv/greedy_coin_change_top.sv
// ----------------------------------------------------------------------------
// Greedy coin change
// Sorted denomination table with a greedy solver built on a shared divider.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load reads and moves up every stored entry
// smaller than the new value, reads one entry more when a larger or equal
// entry stays below it, and writes the new value into the freed slot; a clear
// empties the table as it is accepted. A solve emits one item per stored
// denomination, each passing through a table read, the bit-serial divider and
// the result register, and waits while the output stalls. A zero denomination
// skips the divider, and an empty table gives a single item.
// ----------------------------------------------------------------------------
module greedy_coin_change_top #(
    parameter int MAX_DENOMS = gcc_pkg::MAX_DENOMS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   mode,
    input  logic [gcc_pkg::VALUE_W-1:0]  coin_value,
    input  logic [gcc_pkg::AMOUNT_W-1:0] amount,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [gcc_pkg::POS_W-1:0]    denom_index,
    output logic [gcc_pkg::VALUE_W-1:0]  denom_value,
    output logic [gcc_pkg::AMOUNT_W-1:0] unit_count,
    output logic [gcc_pkg::AMOUNT_W-1:0] remainder,
    output logic                         feasible,
    output logic                         is_last
);

    gcc_pkg::gcc_cmd_t cmd;
    gcc_pkg::gcc_sts_t sts;

    gcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    gcc_dp #(
        .MAX_DENOMS (MAX_DENOMS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .coin_value  (coin_value),
        .amount      (amount),
        .denom_index (denom_index),
        .denom_value (denom_value),
        .unit_count  (unit_count),
        .remainder   (remainder),
        .feasible    (feasible),
        .is_last     (is_last)
    );

    // A result is never shown while the block is taking a new item.
    a_out_excl_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("result shown while input is open");

    a_feas_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && feasible) |-> (is_last && (remainder == '0)))
        else $error("feasible flag on a non-final or nonzero result");

    // After the final result is taken the block is ready again.
    a_last_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && is_last) |=> in_ready)
        else $error("block not idle after final result");

endmodule
